@@ design/life_grid_engine_assert.svh @@
// Assertion macros used by the life grid engine checker.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef LIFE_GRID_ENGINE_ASSERT_SVH
`define LIFE_GRID_ENGINE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define LGE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define LGE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/lge_pkg.sv @@
// Shared types and constants for the life grid engine.
// No dependencies.
package lge_pkg;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;
  localparam int CFG_RESET_DIM  = 64;

  localparam int MODE_W     = 3;
  localparam int COORD_W    = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  typedef enum logic [MODE_W-1:0] {
    MODE_SET  = 3'd0,
    MODE_GET  = 3'd1,
    MODE_FILL = 3'd2,
    MODE_INV  = 3'd3,
    MODE_STEP = 3'd4
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_WIDTH  = 2'd0,
    REG_ACTIVE_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN
  } eng_state_t;

endpackage

@@ design/lge_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lge_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/lge_row_rule.sv @@
// One generation of B3/S23 for a full grid row, from three masked rows.
// Uses nothing from the package.
module lge_row_rule #(
  parameter int WIDTH = 64
) (
  input  logic [WIDTH-1:0] above_i,
  input  logic [WIDTH-1:0] cur_i,
  input  logic [WIDTH-1:0] below_i,
  output logic [WIDTH-1:0] next_o
);

  logic [WIDTH+1:0] a_pad, c_pad, b_pad;

  assign a_pad = {1'b0, above_i, 1'b0};
  assign c_pad = {1'b0, cur_i, 1'b0};
  assign b_pad = {1'b0, below_i, 1'b0};

  // padded index i+1 is cell i; pads are the dead border
  always_comb begin
    logic [3:0] n;
    for (int i = 0; i < WIDTH; i++) begin
      n = {3'b0, a_pad[i]} + {3'b0, a_pad[i+1]} + {3'b0, a_pad[i+2]}
        + {3'b0, c_pad[i]} + {3'b0, c_pad[i+2]}
        + {3'b0, b_pad[i]} + {3'b0, b_pad[i+1]} + {3'b0, b_pad[i+2]};
      next_o[i] = (n == 4'd3) || (cur_i[i] && (n == 4'd2));
    end
  end

endmodule

@@ design/life_grid_engine.sv @@
// Life grid engine top level: command decode, row sequencer, grid RAM.
// Depends on lge_pkg, lge_ram and lge_row_rule.
//
// Usage
//   Input: an operation is taken on a rising edge with start high and busy
//   low (mode, col, row, value sampled there). Config writes (cfg_valid,
//   cfg_index, cfg_data) are always ready and belong in idle periods.
//   Result: out_valid is high for exactly one cycle per operation, with
//   out_cell_value holding the cell read by a get and zero otherwise.
//   The receiver cannot stall; a result is never held back.
// Sequence from accept to the result strobe (h = active height):
//   set, get       row read, modify/pick, strobe
//   fill, invert   h-row sweep, one row read-modify-write per cycle, strobe
//   step           h-row sweep, three-row window, one row per cycle, strobe
//   unused modes   strobe only
// Throughput is set by the single row-wide RAM: one row read and one row
// write per cycle.
// Reset: the grid is cleared by a pass over all MAX_HEIGHT rows, one row per
// cycle, with busy high; config writes are still taken during the pass.
// Active width and height come out of reset as 64, clamped to the maxima.
module life_grid_engine import lge_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [MODE_W-1:0]     in_mode,
  input  logic [COORD_W-1:0]    in_col,
  input  logic [COORD_W-1:0]    in_row,
  input  logic                  in_value,
  output logic                  out_valid,
  output logic                  out_cell_value,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int WW  = $clog2(MAX_WIDTH + 1);   // active width register
  localparam int HW  = $clog2(MAX_HEIGHT + 1);  // active height register
  localparam int CIW = $clog2(MAX_WIDTH);       // column index
  localparam int RAW = $clog2(MAX_HEIGHT);      // row address
  localparam int CW  = $clog2(MAX_HEIGHT + 2);  // sweep counter, up to h+1
  localparam int W_RST = (CFG_RESET_DIM > MAX_WIDTH) ? MAX_WIDTH : CFG_RESET_DIM;
  localparam int H_RST = (CFG_RESET_DIM > MAX_HEIGHT) ? MAX_HEIGHT : CFG_RESET_DIM;

  // control state
  eng_state_t     state_r, state_nxt;
  logic [CW-1:0]  j_r, j_nxt;
  logic [RAW-1:0] clr_r, clr_nxt;
  logic           rd_vld_r;
  logic           out_valid_r, out_valid_nxt;
  logic [WW-1:0]  active_width_r, active_width_nxt;
  logic [HW-1:0]  active_height_r, active_height_nxt;

  // operation payload and line buffers
  mode_t          op_r, op_nxt;
  logic [CIW-1:0] col_r, col_nxt;
  logic [RAW-1:0] row_r, row_nxt;
  logic           val_r, val_nxt;
  logic [MAX_WIDTH-1:0] above_r, above_nxt;
  logic [MAX_WIDTH-1:0] cur_r, cur_nxt;
  logic           out_cell_r, out_cell_nxt;

  // RAM port
  logic                 ram_we, ram_re;
  logic [RAW-1:0]       ram_waddr, ram_raddr;
  logic [MAX_WIDTH-1:0] ram_wdata, ram_rdata;

  logic [MAX_WIDTH-1:0] col_mask, below, rule_row, set_row;
  logic                 mode_ok, j_lt_h;
  logic [CIW-1:0]       col_clamp;
  logic [RAW-1:0]       row_clamp;
  logic [CW-1:0]        j_last, jm1, jm2;

  assign busy           = (state_r != ST_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_cell_value = out_cell_r;

  assign mode_ok = (in_mode == MODE_SET) || (in_mode == MODE_GET) ||
                   (in_mode == MODE_FILL) || (in_mode == MODE_INV) ||
                   (in_mode == MODE_STEP);

  // coordinates clamp to the last active column/row
  assign col_clamp = (32'(in_col) >= 32'(active_width_r)) ?
                     CIW'(active_width_r - WW'(1)) : CIW'(in_col);
  assign row_clamp = (32'(in_row) >= 32'(active_height_r)) ?
                     RAW'(active_height_r - HW'(1)) : RAW'(in_row);

  always_comb begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      col_mask[i] = (i < int'(active_width_r));
    end
  end

  // rows past the bottom read back as dead
  assign below  = rd_vld_r ? ram_rdata : '0;
  assign j_lt_h = (32'(j_r) < 32'(active_height_r));
  assign jm1    = j_r - CW'(1);
  assign jm2    = j_r - CW'(2);

  always_comb begin
    set_row        = ram_rdata;
    set_row[col_r] = val_r;
  end

  always_comb begin
    unique case (op_r)
      MODE_SET, MODE_GET:  j_last = CW'(1);
      MODE_FILL, MODE_INV: j_last = CW'(active_height_r);
      MODE_STEP:           j_last = CW'(active_height_r) + CW'(1);
      default:             j_last = CW'(1);
    endcase
  end

  lge_row_rule #(
    .WIDTH(MAX_WIDTH)
  ) u_rule (
    .above_i(above_r & col_mask),
    .cur_i  (cur_r & col_mask),
    .below_i(below & col_mask),
    .next_o (rule_row)
  );

  lge_ram #(
    .WIDTH(MAX_WIDTH),
    .DEPTH(MAX_HEIGHT)
  ) u_grid (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // configuration: 0 acts as 1, values above the maximum saturate
  always_comb begin
    active_width_nxt  = active_width_r;
    active_height_nxt = active_height_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ACTIVE_WIDTH: begin
          if (cfg_data == '0) begin
            active_width_nxt = WW'(1);
          end else if (32'(cfg_data) > MAX_WIDTH) begin
            active_width_nxt = WW'(MAX_WIDTH);
          end else begin
            active_width_nxt = WW'(cfg_data);
          end
        end
        REG_ACTIVE_HEIGHT: begin
          if (cfg_data == '0) begin
            active_height_nxt = HW'(1);
          end else if (32'(cfg_data) > MAX_HEIGHT) begin
            active_height_nxt = HW'(MAX_HEIGHT);
          end else begin
            active_height_nxt = HW'(cfg_data);
          end
        end
        default: begin
          // unknown index: ignored
        end
      endcase
    end
  end

  // sequencer: clear pass, idle decode, row sweep
  always_comb begin
    state_nxt     = state_r;
    j_nxt         = j_r;
    clr_nxt       = clr_r;
    op_nxt        = op_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    val_nxt       = val_r;
    above_nxt     = above_r;
    cur_nxt       = cur_r;
    out_valid_nxt = 1'b0;
    out_cell_nxt  = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = '0;

    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        if (clr_r == RAW'(MAX_HEIGHT - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + RAW'(1);
        end
      end

      ST_IDLE: begin
        if (start) begin
          if (mode_ok) begin
            op_nxt    = mode_t'(in_mode);
            col_nxt   = col_clamp;
            row_nxt   = row_clamp;
            val_nxt   = in_value;
            j_nxt     = '0;
            above_nxt = '0;
            cur_nxt   = '0;
            state_nxt = ST_RUN;
          end else begin
            // unused mode: no-op, zero result next cycle
            out_valid_nxt = 1'b1;
          end
        end
      end

      ST_RUN: begin
        unique case (op_r)
          MODE_SET, MODE_GET: begin
            ram_re    = (j_r == '0);
            ram_raddr = row_r;
            if ((op_r == MODE_SET) && (j_r != '0)) begin
              ram_we    = 1'b1;
              ram_waddr = row_r;
              ram_wdata = set_row;
            end
          end
          MODE_FILL, MODE_INV: begin
            // read row j, write back row j-1
            ram_re    = j_lt_h;
            ram_raddr = j_r[RAW-1:0];
            if (j_r != '0) begin
              ram_we    = 1'b1;
              ram_waddr = jm1[RAW-1:0];
              if (op_r == MODE_FILL) begin
                ram_wdata = (ram_rdata & ~col_mask) | ({MAX_WIDTH{val_r}} & col_mask);
              end else begin
                ram_wdata = ram_rdata ^ col_mask;
              end
            end
          end
          MODE_STEP: begin
            // read row j, rdata is row j-1, write new row j-2
            ram_re    = j_lt_h;
            ram_raddr = j_r[RAW-1:0];
            if (j_r != '0) begin
              above_nxt = cur_r;
              cur_nxt   = below;
            end
            if (j_r >= CW'(2)) begin
              ram_we    = 1'b1;
              ram_waddr = jm2[RAW-1:0];
              ram_wdata = (cur_r & ~col_mask) | (rule_row & col_mask);
            end
          end
          default: begin
            // never latched: only decoded modes enter the sweep
          end
        endcase

        if (j_r == j_last) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_cell_nxt  = (op_r == MODE_GET) ? ram_rdata[col_r] : 1'b0;
        end else begin
          j_nxt = j_r + CW'(1);
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_CLEAR;
      j_r             <= '0;
      clr_r           <= '0;
      rd_vld_r        <= 1'b0;
      out_valid_r     <= 1'b0;
      active_width_r  <= WW'(W_RST);
      active_height_r <= HW'(H_RST);
    end else begin
      state_r         <= state_nxt;
      j_r             <= j_nxt;
      clr_r           <= clr_nxt;
      rd_vld_r        <= ram_re;
      out_valid_r     <= out_valid_nxt;
      active_width_r  <= active_width_nxt;
      active_height_r <= active_height_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    val_r      <= val_nxt;
    above_r    <= above_nxt;
    cur_r      <= cur_nxt;
    out_cell_r <= out_cell_nxt;
  end

endmodule

@@ design/lge_checker.sv @@
// Port-level checks for the life grid engine, bound to the top level.
// Depends on lge_pkg and life_grid_engine_assert.svh.
`include "life_grid_engine_assert.svh"

module lge_checker import lge_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic [MODE_W-1:0] in_mode,
  input logic              out_valid
);

  logic mode_ok;

  assign mode_ok = (in_mode == MODE_SET) || (in_mode == MODE_GET) ||
                   (in_mode == MODE_FILL) || (in_mode == MODE_INV) ||
                   (in_mode == MODE_STEP);

  // a real operation keeps the engine busy after its transfer
  `LGE_ASSERT_NEXT(a_accept_busy, start && !busy && mode_ok, busy, "operation accepted but not busy")

  // a result only follows engine work or a no-op transfer
  `LGE_ASSERT_NOW(a_result_source, out_valid, $past(busy) || $past(start && !busy), "unexpected result strobe")

  // the clear pass is running when reset is released
  `LGE_ASSERT_NOW(a_clear_after_reset, $rose(rst_n), busy, "not busy clearing after reset")

endmodule

bind life_grid_engine lge_checker u_lge_checker (.*);
